// ===== sv/lphi_pkg.sv =====
// Shared types, codes and helpers of the linear probe hash index.
// No dependencies; all other files but lphi_ram refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package lphi_pkg;

	localparam int SLOTS_DEF       = 64;
	localparam int MAX_ENTRIES_DEF = 48;
	localparam int KEY_BYTES_DEF   = 4;

	localparam logic [63:0] FNV_START   = 64'd5381;
	localparam logic [8:0]  FNV_PRIME_LO = 9'h193;

	localparam logic [1:0] ACT_FIND   = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_ABSENT   = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_REMOVED  = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key;
	} req_t;

	function automatic logic [31:0] key_mask(input logic [31:0] k, input int nbytes);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < nbytes) m[8*i +: 8] = 8'hFF;
		end
		return k & m;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lphi_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lphi_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/lphi_hash.sv =====
// Iterative FNV-1a-like hash (32-bit FNV prime, 64-bit state), one key byte
// a cycle, then reduction modulo SLOTS, four bits a cycle. Needs lphi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lphi_hash #(
	parameter int SLOTS = lphi_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = lphi_pkg::KEY_BYTES_DEF,
	parameter int SW = $clog2(SLOTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   key,
	input  wire logic [63:0]   seed,
	output logic               res_vld,
	output logic      [SW-1:0] home
);
	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_FNV  = 2'd1;
	localparam logic [1:0] H_MOD  = 2'd2;
	localparam logic [SW:0] SL = (SW+1)'(SLOTS);

	logic [1:0]    ph_q;
	logic [3:0]    cnt_q;
	logic          res_q;
	logic [63:0]   h_q;
	logic [63:0]   kb_q;
	logic [SW-1:0] r_q;
	logic [63:0]   t_fnv;
	logic [63:0]   h_fnv;
	logic [SW:0]   t_mod;
	logic [SW-1:0] r_mod;

	always_comb begin
		t_fnv = h_q ^ {56'd0, kb_q[7:0]};
		h_fnv = (t_fnv << 24) + t_fnv * 64'(lphi_pkg::FNV_PRIME_LO);
		r_mod = r_q;
		t_mod = '0;
		for (int j = 0; j < 4; j++) begin
			t_mod = {r_mod, h_q[63-j]};
			if (t_mod >= SL) t_mod = t_mod - SL;
			r_mod = t_mod[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= H_IDLE;
			cnt_q <= '0;
			res_q <= 1'b0;
		end else if (start) begin
			ph_q  <= H_FNV;
			cnt_q <= '0;
			res_q <= 1'b0;
		end else begin
			case (ph_q)
				H_FNV: begin
					if (cnt_q == 4'(KEY_BYTES-1)) begin
						cnt_q <= '0;
						ph_q  <= H_MOD;
					end else cnt_q <= cnt_q + 1'b1;
				end
				H_MOD: begin
					if (cnt_q == 4'd15) begin
						ph_q  <= H_IDLE;
						res_q <= 1'b1;
					end else cnt_q <= cnt_q + 1'b1;
				end
				default: ph_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q  <= (seed == 64'd0) ? lphi_pkg::FNV_START : seed;
			kb_q <= {32'd0, key};
			r_q  <= '0;
		end else if (ph_q == H_FNV) begin
			h_q  <= h_fnv;
			kb_q <= kb_q >> 8;
		end else if (ph_q == H_MOD) begin
			h_q <= h_q << 4;
			r_q <= r_mod;
		end
	end

	assign res_vld = res_q;
	assign home    = r_q;
endmodule
`default_nettype wire

// ===== sv/lphi_front.sv =====
// Front end: takes requests, masks the key, hashes it to a home slot and
// queues the classified request. Depends on lphi_pkg and lphi_hash.
`timescale 1ns / 1ps
`default_nettype none
module lphi_front #(
	parameter int SLOTS = lphi_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = lphi_pkg::KEY_BYTES_DEF,
	parameter int SW = $clog2(SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [63:0]       seed,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [1:0]        action,
	input  wire logic [31:0]       key,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output lphi_pkg::req_t         q_req,
	output logic      [SW-1:0]     q_home
);
	logic           pend_q;
	lphi_pkg::req_t cur_q;
	lphi_pkg::req_t ent_q [2];
	logic [SW-1:0]  home_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     fill_q;
	logic           take;
	logic           push;
	logic           pop;
	logic           h_vld;
	logic [SW-1:0]  h_home;
	logic [31:0]    kmask;

	assign kmask     = lphi_pkg::key_mask(key, KEY_BYTES);
	assign req_ready = !pend_q;
	assign take      = req_valid && !pend_q;
	assign push      = pend_q && h_vld && (fill_q != 2'd2);
	assign pop       = q_valid && q_ready;
	assign q_valid   = (fill_q != 2'd0);
	assign q_req     = ent_q[rp_q];
	assign q_home    = home_q[rp_q];

	lphi_hash #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .SW(SW)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(take), .key(kmask), .seed(seed),
		.res_vld(h_vld), .home(h_home)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (take) pend_q <= 1'b1;
			else if (push) pend_q <= 1'b0;
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q.action <= action;
			cur_q.key    <= kmask;
		end
		if (push) begin
			ent_q[wp_q]  <= cur_q;
			home_q[wp_q] <= h_home;
		end
	end
endmodule
`default_nettype wire

// ===== sv/lphi_back.sv =====
// Back end: probes the slot table, appends and removes entries and rebuilds
// the cluster after a removal. Depends on lphi_pkg, lphi_ram and lphi_hash.
`timescale 1ns / 1ps
`default_nettype none
module lphi_back #(
	parameter int SLOTS = lphi_pkg::SLOTS_DEF,
	parameter int MAX_ENTRIES = lphi_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BYTES = lphi_pkg::KEY_BYTES_DEF,
	parameter int SW = $clog2(SLOTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [63:0]   seed,
	input  wire logic          q_valid,
	output logic               q_ready,
	input  wire lphi_pkg::req_t q_req,
	input  wire logic [SW-1:0] q_home,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output logic      [2:0]    status,
	output logic      [5:0]    entry_index,
	output logic      [5:0]    slot,
	output logic      [5:0]    count
);
	localparam int VW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
	localparam logic [VW-1:0] MAXV = VW'(MAX_ENTRIES);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_PRD   = 5'd1;
	localparam logic [4:0] S_PCHK  = 5'd2;
	localparam logic [4:0] S_PKEY  = 5'd3;
	localparam logic [4:0] S_DEC   = 5'd4;
	localparam logic [4:0] S_RST   = 5'd5;
	localparam logic [4:0] S_MVRD  = 5'd6;
	localparam logic [4:0] S_MVH   = 5'd7;
	localparam logic [4:0] S_MRD   = 5'd8;
	localparam logic [4:0] S_MCHK  = 5'd9;
	localparam logic [4:0] S_CLR   = 5'd10;
	localparam logic [4:0] S_CRD   = 5'd11;
	localparam logic [4:0] S_CCHK  = 5'd12;
	localparam logic [4:0] S_RKEY  = 5'd13;
	localparam logic [4:0] S_RH    = 5'd14;
	localparam logic [4:0] S_PLRD  = 5'd15;
	localparam logic [4:0] S_PLCHK = 5'd16;
	localparam logic [4:0] S_CNXT  = 5'd17;
	localparam logic [4:0] S_RDONE = 5'd18;

	logic [4:0]    st_q;
	logic [1:0]    act_q;
	logic [31:0]   key_q;
	logic [SW-1:0] home_q;
	logic [SW-1:0] s_q;
	logic [SW-1:0] n_q;
	logic [SW-1:0] p_q;
	logic [SW-1:0] m_q;
	logic [SW-1:0] rm_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] vr_q;
	logic [IW-1:0] idx_q;
	logic          hit_q;
	logic          emp_q;
	logic [VW-1:0] cnt_q;
	logic [SLOTS-1:0] slot_vld_q;
	logic          vld_rd_q;
	logic          out_vld_q;
	logic [2:0]    out_st_q;
	logic [IW-1:0] out_idx_q;
	logic [SW-1:0] out_slot_q;

	logic          slot_we;
	logic [SW-1:0] slot_waddr;
	logic [VW-1:0] slot_wdata;
	logic [SW-1:0] slot_raddr;
	logic [VW-1:0] slot_rd;
	logic          key_we;
	logic [IW-1:0] key_waddr;
	logic [31:0]   key_wdata;
	logic [IW-1:0] key_raddr;
	logic [31:0]   key_rd;
	logic          h_start;
	logic          h_vld;
	logic [SW-1:0] h_home;
	logic [VW-1:0] v;
	logic [SW-1:0] s_nx;
	logic [SW-1:0] p_nx;
	logic          ins_ok;

	assign v      = vld_rd_q ? slot_rd : '0;
	assign s_nx   = (s_q == LAST) ? '0 : s_q + 1'b1;
	assign p_nx   = (p_q == LAST) ? '0 : p_q + 1'b1;
	assign ins_ok = !hit_q && emp_q && (cnt_q < MAXV);
	assign q_ready = (st_q == S_IDLE) && !out_vld_q;

	lphi_ram #(.W(VW), .D(SLOTS), .AW(SW)) u_slots (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rd)
	);

	lphi_ram #(.W(32), .D(MAX_ENTRIES), .AW(IW)) u_keys (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rd)
	);

	lphi_hash #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .SW(SW)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(h_start), .key(key_rd), .seed(seed),
		.res_vld(h_vld), .home(h_home)
	);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = s_q;
		slot_wdata = '0;
		slot_raddr = s_q;
		key_we     = 1'b0;
		key_waddr  = idx_q;
		key_wdata  = key_rd;
		key_raddr  = '0;
		h_start    = 1'b0;
		case (st_q)
			S_PCHK: key_raddr = IW'(v - 1'b1);
			S_DEC: begin
				if (act_q == lphi_pkg::ACT_INSERT && ins_ok) begin
					key_we     = 1'b1;
					key_waddr  = IW'(cnt_q);
					key_wdata  = key_q;
					slot_we    = 1'b1;
					slot_wdata = cnt_q + 1'b1;
				end
			end
			S_RST: key_raddr = IW'(cnt_q - 1'b1);
			S_MVRD: begin
				key_we  = 1'b1;
				h_start = 1'b1;
			end
			S_MCHK: begin
				if (v != '0 && v == cnt_q + 1'b1) begin
					slot_we    = 1'b1;
					slot_wdata = VW'(idx_q) + 1'b1;
				end
			end
			S_CLR: begin
				slot_we    = 1'b1;
				slot_waddr = rm_q;
			end
			S_CCHK: begin
				if (v != '0) begin
					slot_we   = 1'b1;
					key_raddr = IW'(v - 1'b1);
				end
			end
			S_RKEY: h_start = 1'b1;
			S_PLRD: slot_raddr = p_q;
			S_PLCHK: begin
				if (v == '0) begin
					slot_we    = 1'b1;
					slot_waddr = p_q;
					slot_wdata = vr_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cnt_q      <= '0;
			slot_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (slot_we) slot_vld_q[slot_waddr] <= 1'b1;
			if (out_vld_q && rsp_ready) out_vld_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_valid && !out_vld_q) st_q <= S_PRD;
				S_PRD: st_q <= S_PCHK;
				S_PCHK: begin
					if (v == '0 || v <= cnt_q) st_q <= (v == '0) ? S_DEC : S_PKEY;
					else if (n_q == LAST) st_q <= S_DEC;
					else st_q <= S_PRD;
				end
				S_PKEY: begin
					if (key_rd == key_q || n_q == LAST) st_q <= S_DEC;
					else st_q <= S_PRD;
				end
				S_DEC: begin
					if (act_q == lphi_pkg::ACT_REMOVE && hit_q) st_q <= S_RST;
					else begin
						st_q      <= S_IDLE;
						out_vld_q <= 1'b1;
						if (act_q == lphi_pkg::ACT_INSERT && ins_ok) cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RST: begin
					cnt_q <= cnt_q - 1'b1;
					st_q  <= (VW'(idx_q) < cnt_q - 1'b1) ? S_MVRD : S_CLR;
				end
				S_MVRD: st_q <= S_MVH;
				S_MVH: if (h_vld) st_q <= S_MRD;
				S_MRD: st_q <= S_MCHK;
				S_MCHK: begin
					if (v == '0 || v == cnt_q + 1'b1 || n_q == LAST) st_q <= S_CLR;
					else st_q <= S_MRD;
				end
				S_CLR: st_q <= S_CRD;
				S_CRD: st_q <= S_CCHK;
				S_CCHK: begin
					if (v == '0) st_q <= S_RDONE;
					else st_q <= (v <= MAXV) ? S_RKEY : S_CNXT;
				end
				S_RKEY: st_q <= S_RH;
				S_RH: if (h_vld) st_q <= S_PLRD;
				S_PLRD: st_q <= S_PLCHK;
				S_PLCHK: begin
					if (v == '0 || m_q == LAST) st_q <= S_CNXT;
					else st_q <= S_PLRD;
				end
				S_CNXT: st_q <= (n_q == LAST) ? S_RDONE : S_CRD;
				S_RDONE: begin
					st_q      <= S_IDLE;
					out_vld_q <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= slot_vld_q[slot_raddr];
		case (st_q)
			S_IDLE: begin
				act_q  <= q_req.action;
				key_q  <= q_req.key;
				home_q <= q_home;
				s_q    <= q_home;
				n_q    <= '0;
			end
			S_PCHK: begin
				v_q <= v;
				if (v == '0) begin
					hit_q <= 1'b0;
					emp_q <= 1'b1;
				end else if (v > cnt_q) begin
					if (n_q == LAST) begin
						hit_q <= 1'b0;
						emp_q <= 1'b0;
						s_q   <= home_q;
					end else begin
						s_q <= s_nx;
						n_q <= n_q + 1'b1;
					end
				end
			end
			S_PKEY: begin
				if (key_rd == key_q) begin
					hit_q <= 1'b1;
					idx_q <= IW'(v_q - 1'b1);
				end else if (n_q == LAST) begin
					hit_q <= 1'b0;
					emp_q <= 1'b0;
					s_q   <= home_q;
				end else begin
					s_q <= s_nx;
					n_q <= n_q + 1'b1;
				end
			end
			S_DEC: begin
				rm_q       <= s_q;
				out_slot_q <= s_q;
				out_idx_q  <= '0;
				if (act_q == lphi_pkg::ACT_INSERT) begin
					if (hit_q) begin
						out_st_q  <= lphi_pkg::ST_FOUND;
						out_idx_q <= idx_q;
					end else if (ins_ok) begin
						out_st_q  <= lphi_pkg::ST_INSERTED;
						out_idx_q <= IW'(cnt_q);
					end else out_st_q <= lphi_pkg::ST_FULL;
				end else if (hit_q && act_q != lphi_pkg::ACT_REMOVE) begin
					out_st_q  <= lphi_pkg::ST_FOUND;
					out_idx_q <= idx_q;
				end else out_st_q <= lphi_pkg::ST_ABSENT;
			end
			S_MVH: begin
				s_q <= h_home;
				n_q <= '0;
			end
			S_MCHK: begin
				s_q <= s_nx;
				n_q <= n_q + 1'b1;
			end
			S_CLR: begin
				s_q <= (rm_q == LAST) ? '0 : rm_q + 1'b1;
				n_q <= SW'(1);
			end
			S_CCHK: vr_q <= v;
			S_RH: begin
				p_q <= h_home;
				m_q <= '0;
			end
			S_PLCHK: begin
				p_q <= p_nx;
				m_q <= m_q + 1'b1;
			end
			S_CNXT: begin
				s_q <= s_nx;
				n_q <= n_q + 1'b1;
			end
			S_RDONE: begin
				out_st_q   <= lphi_pkg::ST_REMOVED;
				out_idx_q  <= '0;
				out_slot_q <= rm_q;
			end
			default: ;
		endcase
	end

	assign rsp_valid   = out_vld_q;
	assign status      = out_st_q;
	assign entry_index = 6'(out_idx_q);
	assign slot        = 6'(out_slot_q);
	assign count       = 6'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXV)
		else $error("entry count above capacity");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && out_vld_q) |=> (st_q == S_IDLE))
		else $error("request started while a response waits");

	a_slot_val: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |-> (slot_wdata <= MAXV))
		else $error("slot written with an index past capacity");
endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_index_unit.sv =====
// The front hashes each request, one key byte then four modulo bits a cycle,
// and the back probes slot after slot. The front takes a new request only
// once the hash of the last one is in its queue, and a removal holds the back
// longer while it rebuilds its cluster, each entry of it being hashed again.
// Reset: asynchronous, active low; empties the slot table through per-slot
// valid bits, clears the entry count, the seed and the queue at once.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_index_unit #(
	parameter int SLOTS = lphi_pkg::SLOTS_DEF,
	parameter int MAX_ENTRIES = lphi_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BYTES = lphi_pkg::KEY_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] key,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic      [2:0]  status,
	output logic      [5:0]  entry_index,
	output logic      [5:0]  slot,
	output logic      [5:0]  count
);
	localparam int SW = $clog2(SLOTS);

	logic [63:0]    seed_q;
	logic           q_valid;
	logic           q_ready;
	lphi_pkg::req_t q_req;
	logic [SW-1:0]  q_home;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == 1'b0) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (psel && penable && pwrite && paddr[3] == 1'b0) seed_q <= pwdata;
	end

	lphi_front #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .SW(SW)) u_front (
		.clk(clk), .arst_n(arst_n), .seed(seed_q),
		.req_valid(req_valid), .req_ready(req_ready), .action(action), .key(key),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_home(q_home)
	);

	lphi_back #(.SLOTS(SLOTS), .MAX_ENTRIES(MAX_ENTRIES), .KEY_BYTES(KEY_BYTES),
		.SW(SW)) u_back (
		.clk(clk), .arst_n(arst_n), .seed(seed_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_home(q_home),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
		.entry_index(entry_index), .slot(slot), .count(count)
	);
endmodule
`default_nettype wire
